/* hw/rtl/scba_pkg.sv */
// Shared types, constants and helper functions for the size class block allocator.
// Used by every module in hw/rtl but scba_ram; depends on nothing else.
package scba_pkg;

    localparam int SMALL_BLOCKS  = 32;
    localparam int MEDIUM_BLOCKS = 16;
    localparam int LARGE_BLOCKS  = 8;
    localparam int POOL_COUNT    = 3;
    localparam int POOLS         = 3;

    function automatic int idx_bits(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

    function automatic int max3(input int a, input int b, input int c);
        int m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    localparam int SMALL_W    = idx_bits(SMALL_BLOCKS);
    localparam int MEDIUM_W   = idx_bits(MEDIUM_BLOCKS);
    localparam int LARGE_W    = idx_bits(LARGE_BLOCKS);
    localparam int MAX_BLOCKS = max3(SMALL_BLOCKS, MEDIUM_BLOCKS, LARGE_BLOCKS);
    localparam int IDX_W      = idx_bits(MAX_BLOCKS);
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
    localparam int CMP_W      = CNT_W + 5;
    localparam int SIZE_W     = 16;
    localparam int ADDR_W     = 4;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;

    localparam logic [1:0] POOL_SMALL  = 2'd0;
    localparam logic [1:0] POOL_MEDIUM = 2'd1;
    localparam logic [1:0] POOL_LARGE  = 2'd2;
    localparam logic [1:0] POOL_NONE   = 2'd3;

    localparam logic [1:0] ST_ALLOC   = 2'd0;
    localparam logic [1:0] ST_TOO_BIG = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;
    localparam logic [1:0] ST_FREED   = 2'd3;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [1:0] REG_SMALL  = 2'd0;
    localparam logic [1:0] REG_MEDIUM = 2'd1;
    localparam logic [1:0] REG_LARGE  = 2'd2;

    localparam logic [SIZE_W-1:0] SMALL_SIZE_RST  = 16'd16;
    localparam logic [SIZE_W-1:0] MEDIUM_SIZE_RST = 16'd64;
    localparam logic [SIZE_W-1:0] LARGE_SIZE_RST  = 16'd256;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic capture;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic [SIZE_W-1:0] small_size;
        logic [SIZE_W-1:0] medium_size;
        logic [SIZE_W-1:0] large_size;
    } t_sizes;

    function automatic t_cnt pool_blocks(input logic [1:0] p);
        t_cnt n;
        unique case (p)
            POOL_SMALL:  n = CNT_W'(SMALL_BLOCKS);
            POOL_MEDIUM: n = CNT_W'(MEDIUM_BLOCKS);
            POOL_LARGE:  n = CNT_W'(LARGE_BLOCKS);
            default:     n = '0;
        endcase
        return n;
    endfunction

    // Link value that an entry holds before it is first written.
    function automatic t_idx reset_link(input logic [1:0] p, input t_idx head);
        logic [CNT_W:0] nxt;
        nxt = (CNT_W+1)'(head) + 1'b1;
        return (nxt < {1'b0, pool_blocks(p)}) ? IDX_W'(nxt) : '0;
    endfunction

endpackage

/* hw/rtl/scba_ram.sv */
// Generic single write port, single read port RAM with a registered read.
// Holds the free list links of one pool; no dependencies.
module scba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/scba_cfg.sv */
// Configuration register file holding the three block size limits.
// APB-style write and read access; depends on scba_pkg.
module scba_cfg import scba_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output t_sizes            o_sizes
);

    logic [SIZE_W-1:0] r_small_size;
    logic [SIZE_W-1:0] r_medium_size;
    logic [SIZE_W-1:0] r_large_size;
    logic              w_wr;
    logic [1:0]        w_reg;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_reg  = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_small_size  <= SMALL_SIZE_RST;
            r_medium_size <= MEDIUM_SIZE_RST;
            r_large_size  <= LARGE_SIZE_RST;
        end else if (w_wr) begin
            unique case (w_reg)
                REG_SMALL:  r_small_size  <= pwdata[SIZE_W-1:0];
                REG_MEDIUM: r_medium_size <= pwdata[SIZE_W-1:0];
                REG_LARGE:  r_large_size  <= pwdata[SIZE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_reg)
            REG_SMALL:  prdata = {16'd0, r_small_size};
            REG_MEDIUM: prdata = {16'd0, r_medium_size};
            REG_LARGE:  prdata = {16'd0, r_large_size};
            default:    prdata = '0;
        endcase
    end

    assign o_sizes = '{small_size: r_small_size, medium_size: r_medium_size,
                       large_size: r_large_size};

endmodule

/* hw/rtl/scba_ctrl.sv */
// Controller state machine: sequences capture and commit of each transaction.
// Drives the datapath command struct and the output valid; depends on scba_pkg.
module scba_ctrl import scba_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_slot_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_cmd.capture = 1'b0;
        o_cmd.commit  = 1'b0;
        o_in_ready    = 1'b0;
        w_slot_free   = !r_out_valid || i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_slot_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

/* hw/rtl/scba_dp.sv */
// Datapath: list heads, free counts, link memories and the result register.
// Acts on capture and commit commands from scba_ctrl; depends on scba_pkg and scba_ram.
module scba_dp import scba_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    input  t_sizes            i_sizes,
    input  logic              i_command,
    input  logic [SIZE_W-1:0] i_request_size,
    input  logic [1:0]        i_free_pool,
    input  logic [4:0]        i_free_block,
    output logic [1:0]        o_status,
    output logic [1:0]        o_pool_id,
    output logic [4:0]        o_block_index,
    output logic [5:0]        o_blocks_left
);

    logic              r_cmd;
    logic [SIZE_W-1:0] r_size;
    logic [1:0]        r_fp;
    logic [4:0]        r_fb;
    t_idx              r_head [POOLS];
    t_cnt              r_cnt  [POOLS];
    logic              r_rdv  [POOLS];
    logic [SMALL_BLOCKS-1:0]  r_vld_s;
    logic [MEDIUM_BLOCKS-1:0] r_vld_m;
    logic [LARGE_BLOCKS-1:0]  r_vld_l;
    logic [1:0]        r_status;
    logic [1:0]        r_pool;
    logic [4:0]        r_block;
    logic [5:0]        r_left;

    logic [SMALL_W-1:0]  w_rd_s;
    logic [MEDIUM_W-1:0] w_rd_m;
    logic [LARGE_W-1:0]  w_rd_l;
    t_idx              w_link [POOLS];
    logic [1:0]        w_cls;
    logic              w_alloc_ok;
    t_cnt              w_cnt_a;
    t_idx              w_head_a;
    t_idx              w_link_a;
    t_cnt              w_cnt_f;
    t_cnt              w_blk_f;
    t_cnt              w_cnt_dec;
    t_cnt              w_cnt_inc;
    t_idx              w_fb_ext;
    logic              w_free_ok;
    logic              w_alloc_go;
    logic              w_free_go;
    logic              w_we_s;
    logic              w_we_m;
    logic              w_we_l;
    logic [1:0]        n_status;
    logic [1:0]        n_pool;
    logic [4:0]        n_block;
    logic [5:0]        n_left;

    scba_ram #(.WIDTH(SMALL_W), .DEPTH(SMALL_BLOCKS)) u_small_links (
        .i_clk   (i_clk),
        .i_we    (w_we_s),
        .i_waddr (w_fb_ext[SMALL_W-1:0]),
        .i_wdata (r_head[0][SMALL_W-1:0]),
        .i_re    (i_cmd.capture),
        .i_raddr (r_head[0][SMALL_W-1:0]),
        .o_rdata (w_rd_s)
    );

    scba_ram #(.WIDTH(MEDIUM_W), .DEPTH(MEDIUM_BLOCKS)) u_medium_links (
        .i_clk   (i_clk),
        .i_we    (w_we_m),
        .i_waddr (w_fb_ext[MEDIUM_W-1:0]),
        .i_wdata (r_head[1][MEDIUM_W-1:0]),
        .i_re    (i_cmd.capture),
        .i_raddr (r_head[1][MEDIUM_W-1:0]),
        .o_rdata (w_rd_m)
    );

    scba_ram #(.WIDTH(LARGE_W), .DEPTH(LARGE_BLOCKS)) u_large_links (
        .i_clk   (i_clk),
        .i_we    (w_we_l),
        .i_waddr (w_fb_ext[LARGE_W-1:0]),
        .i_wdata (r_head[2][LARGE_W-1:0]),
        .i_re    (i_cmd.capture),
        .i_raddr (r_head[2][LARGE_W-1:0]),
        .o_rdata (w_rd_l)
    );

    // Entries never written since reset still hold their initial chain.
    assign w_link[0] = r_rdv[0] ? IDX_W'(w_rd_s) : reset_link(POOL_SMALL, r_head[0]);
    assign w_link[1] = r_rdv[1] ? IDX_W'(w_rd_m) : reset_link(POOL_MEDIUM, r_head[1]);
    assign w_link[2] = r_rdv[2] ? IDX_W'(w_rd_l) : reset_link(POOL_LARGE, r_head[2]);

    assign w_fb_ext = IDX_W'(r_fb);

    always_comb begin
        priority if (r_size <= i_sizes.small_size) begin
            w_cls = POOL_SMALL;
        end else if (r_size <= i_sizes.medium_size) begin
            w_cls = POOL_MEDIUM;
        end else if (r_size <= i_sizes.large_size) begin
            w_cls = POOL_LARGE;
        end else begin
            w_cls = POOL_NONE;
        end
    end

    always_comb begin
        unique case (w_cls)
            POOL_SMALL: begin
                w_cnt_a = r_cnt[0]; w_head_a = r_head[0]; w_link_a = w_link[0];
            end
            POOL_MEDIUM: begin
                w_cnt_a = r_cnt[1]; w_head_a = r_head[1]; w_link_a = w_link[1];
            end
            POOL_LARGE: begin
                w_cnt_a = r_cnt[2]; w_head_a = r_head[2]; w_link_a = w_link[2];
            end
            default: begin
                w_cnt_a = '0; w_head_a = '0; w_link_a = '0;
            end
        endcase
        unique case (r_fp)
            POOL_SMALL:  w_cnt_f = r_cnt[0];
            POOL_MEDIUM: w_cnt_f = r_cnt[1];
            POOL_LARGE:  w_cnt_f = r_cnt[2];
            default:     w_cnt_f = '0;
        endcase
    end

    assign w_blk_f    = pool_blocks(r_fp);
    assign w_alloc_ok = w_cls < 2'(POOL_COUNT);
    assign w_free_ok  = (r_fp < 2'(POOL_COUNT)) && (CMP_W'(r_fb) < CMP_W'(w_blk_f))
                        && (w_cnt_f < w_blk_f);
    assign w_cnt_dec  = w_cnt_a - 1'b1;
    assign w_cnt_inc  = w_cnt_f + 1'b1;
    assign w_alloc_go = i_cmd.commit && (r_cmd == CMD_ALLOC) && w_alloc_ok && (w_cnt_a != '0);
    assign w_free_go  = i_cmd.commit && (r_cmd == CMD_FREE) && w_free_ok;
    assign w_we_s     = w_free_go && (r_fp == POOL_SMALL);
    assign w_we_m     = w_free_go && (r_fp == POOL_MEDIUM);
    assign w_we_l     = w_free_go && (r_fp == POOL_LARGE);

    always_comb begin
        n_status = ST_TOO_BIG;
        n_pool   = POOL_SMALL;
        n_block  = '0;
        n_left   = '0;
        if (r_cmd == CMD_ALLOC) begin
            if (!w_alloc_ok) begin
                n_status = ST_TOO_BIG;
            end else if (w_cnt_a == '0) begin
                n_status = ST_EMPTY;
                n_pool   = w_cls;
            end else begin
                n_status = ST_ALLOC;
                n_pool   = w_cls;
                n_block  = 5'(w_head_a);
                n_left   = 6'(w_cnt_dec);
            end
        end else begin
            n_pool  = r_fp;
            n_block = r_fb;
            if (w_free_ok) begin
                n_status = ST_FREED;
                n_left   = 6'(w_cnt_inc);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd    <= i_command;
            r_size   <= i_request_size;
            r_fp     <= i_free_pool;
            r_fb     <= i_free_block;
            r_rdv[0] <= r_vld_s[r_head[0][SMALL_W-1:0]];
            r_rdv[1] <= r_vld_m[r_head[1][MEDIUM_W-1:0]];
            r_rdv[2] <= r_vld_l[r_head[2][LARGE_W-1:0]];
        end
        if (i_cmd.commit) begin
            r_status <= n_status;
            r_pool   <= n_pool;
            r_block  <= n_block;
            r_left   <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < POOLS; p++) begin
                r_head[p] <= '0;
                r_cnt[p]  <= pool_blocks(2'(p));
            end
            r_vld_s <= '0;
            r_vld_m <= '0;
            r_vld_l <= '0;
        end else begin
            for (int p = 0; p < POOLS; p++) begin
                if (w_alloc_go && (w_cls == 2'(p))) begin
                    r_head[p] <= w_link_a;
                    r_cnt[p]  <= w_cnt_dec;
                end
                if (w_free_go && (r_fp == 2'(p))) begin
                    r_head[p] <= w_fb_ext;
                    r_cnt[p]  <= w_cnt_inc;
                end
            end
            if (w_we_s) begin
                r_vld_s[w_fb_ext[SMALL_W-1:0]] <= 1'b1;
            end
            if (w_we_m) begin
                r_vld_m[w_fb_ext[MEDIUM_W-1:0]] <= 1'b1;
            end
            if (w_we_l) begin
                r_vld_l[w_fb_ext[LARGE_W-1:0]] <= 1'b1;
            end
        end
    end

    assign o_status      = r_status;
    assign o_pool_id     = r_pool;
    assign o_block_index = r_block;
    assign o_blocks_left = r_left;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt[0] <= pool_blocks(POOL_SMALL)) && (r_cnt[1] <= pool_blocks(POOL_MEDIUM))
        && (r_cnt[2] <= pool_blocks(POOL_LARGE)))
        else $error("Free count exceeds the pool size.");

    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CMP_W'(r_head[0]) < CMP_W'(pool_blocks(POOL_SMALL)))
        && (CMP_W'(r_head[1]) < CMP_W'(pool_blocks(POOL_MEDIUM)))
        && (CMP_W'(r_head[2]) < CMP_W'(pool_blocks(POOL_LARGE))))
        else $error("List head points outside its pool.");

    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> $past(i_cmd.capture) || $past(i_cmd.commit) == 1'b0)
        else $error("Commit issued without a captured transaction.");

endmodule

/* hw/rtl/size_class_block_allocator.sv */
// Top level of the size class block allocator.
// Instantiates scba_cfg, scba_ctrl and scba_dp; depends on scba_pkg.
//
// The block serves three fixed-size pools kept as linked free lists.
// An input transaction either allocates a block for a byte size or frees
// a block back to its pool; every input transaction yields exactly one
// output transaction with status, pool, block and the pool's free count.
// Both channels use valid and ready. An input transaction is taken in the
// idle state; the link memory read of the list head is registered while the
// controller moves to the execute state, and the result is registered once the
// output register is free, which raises output valid. No new input transaction
// is taken until the result of the last one has been registered.
// A new input transaction is taken while a result still waits; if the
// receiver stalls, the following result holds inside the block until the
// output register drains. Reset restores the size registers to 16, 64 and
// 256 bytes, fills every pool and chains each list in index order; no
// clearing pass is needed. Size registers are written over the APB port.
module size_class_block_allocator import scba_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_command,
    input  logic [SIZE_W-1:0] i_request_size,
    input  logic [1:0]        i_free_pool,
    input  logic [4:0]        i_free_block,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [1:0]        o_status,
    output logic [1:0]        o_pool_id,
    output logic [4:0]        o_block_index,
    output logic [5:0]        o_blocks_left
);

    t_sizes  w_sizes;
    t_dp_cmd w_cmd;

    scba_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_sizes (w_sizes)
    );

    scba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    scba_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_sizes        (w_sizes),
        .i_command      (i_command),
        .i_request_size (i_request_size),
        .i_free_pool    (i_free_pool),
        .i_free_block   (i_free_block),
        .o_status       (o_status),
        .o_pool_id      (o_pool_id),
        .o_block_index  (o_block_index),
        .o_blocks_left  (o_blocks_left)
    );

endmodule

/* test/tb_size_class_block_allocator.sv */
`timescale 1ns / 100ps
// Self-checking testbench for size_class_block_allocator: allocate and free traffic
// under several block size settings. Depends on scba_pkg and the allocator RTL.
module tb_size_class_block_allocator import scba_pkg::*; ();

    typedef struct packed {
        logic        cmd;
        logic [15:0] size;
        logic [1:0]  pool;
        logic [4:0]  block;
        logic        reuse;
    } t_request;

    typedef struct packed {
        logic [1:0] status;
        logic [1:0] pool;
        logic [4:0] block;
        logic [5:0] left;
    } t_reply;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_command = CMD_ALLOC;
    logic [SIZE_W-1:0] i_request_size = '0;
    logic [1:0]  i_free_pool = '0;
    logic [4:0]  i_free_block = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_status;
    logic [1:0]  o_pool_id;
    logic [4:0]  o_block_index;
    logic [5:0]  o_blocks_left;

    // Shadow of the allocator: free lists, counts and size classes.
    logic [4:0]  pool_next [0:2][0:31];
    logic [4:0]  pool_head [0:2];
    int          pool_free [0:2];
    int          pool_cap [0:2];
    logic [15:0] size_limit [0:2];
    logic        in_use [0:2][0:31];

    t_request request_q [$];
    t_reply   reply_q [$];

    int in_sent = 0, in_taken = 0, in_seen = 0, gap_left = 0;
    int out_taken = 0, out_seen = 0, hold_left = 0;
    logic in_calm = 1'b0, out_calm = 1'b0;
    int mismatches = 0, stall_cycles = 0, settings = 0;
    int n_alloc = 0, n_empty = 0, n_too_big = 0, n_freed = 0, n_refused = 0;

    size_class_block_allocator uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_request_size (i_request_size),
        .i_free_pool    (i_free_pool),
        .i_free_block   (i_free_block),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_pool_id      (o_pool_id),
        .o_block_index  (o_block_index),
        .o_blocks_left  (o_blocks_left)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_reply allocator_reply(input t_request rq);
        t_reply r;
        logic [1:0] p;
        logic bad;
        r = '0;
        if (rq.cmd == CMD_ALLOC) begin
            if (rq.size <= size_limit[0]) p = POOL_SMALL;
            else if (rq.size <= size_limit[1]) p = POOL_MEDIUM;
            else if (rq.size <= size_limit[2]) p = POOL_LARGE;
            else p = POOL_NONE;
            if (int'(p) >= POOL_COUNT) begin
                r.status = ST_TOO_BIG;
                r.pool = POOL_SMALL;
                n_too_big++;
            end else if (pool_free[p] == 0) begin
                r.status = ST_EMPTY;
                r.pool = p;
                n_empty++;
            end else begin
                r.status = ST_ALLOC;
                r.pool = p;
                r.block = pool_head[p];
                in_use[p][pool_head[p]] = 1'b1;
                pool_head[p] = pool_next[p][pool_head[p]];
                pool_free[p]--;
                r.left = 6'(pool_free[p]);
                n_alloc++;
            end
        end else begin
            p = rq.pool;
            r.pool = p;
            r.block = rq.block;
            if (int'(p) >= POOL_COUNT) bad = 1'b1;
            else bad = (int'(rq.block) >= pool_cap[p]) || (pool_free[p] >= pool_cap[p]);
            if (bad) begin
                r.status = ST_TOO_BIG;
                n_refused++;
            end else begin
                pool_next[p][rq.block] = pool_head[p];
                pool_head[p] = rq.block;
                in_use[p][rq.block] = 1'b0;
                pool_free[p]++;
                r.status = ST_FREED;
                r.left = 6'(pool_free[p]);
                n_freed++;
            end
        end
        return r;
    endfunction

    always @(negedge i_clk) begin : request_driver
        t_request rq;
        int start, k, b;
        logic found;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (in_taken != in_seen) begin
                in_seen = in_taken;
                if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
                gap_left = in_calm ? 0 : $urandom_range(0, 10);
            end
            if (in_sent == in_taken) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else if (request_q.size() != 0) begin
                    rq = request_q.pop_front();
                    if (rq.cmd == CMD_FREE && rq.reuse) begin
                        start = $urandom_range(0, 31);
                        found = 1'b0;
                        for (k = 0; k < 32; k++) begin
                            b = (start + k) % 32;
                            if (!found && b < pool_cap[rq.pool] && in_use[rq.pool][b]) begin
                                rq.block = 5'(b);
                                found = 1'b1;
                            end
                        end
                    end
                    i_command <= rq.cmd;
                    i_request_size <= rq.size;
                    i_free_pool <= rq.pool;
                    i_free_block <= rq.block;
                    in_sent++;
                end
            end
            i_in_valid <= (in_sent != in_taken);
        end
    end

    always @(negedge i_clk) begin
        if (out_taken != out_seen) begin
            out_seen = out_taken;
            if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
            hold_left = out_calm ? 0 : $urandom_range(0, 10);
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : reply_monitor
        t_request rq;
        t_reply want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                out_taken++;
                if (reply_q.size() == 0) begin
                    $error("output transaction with no reply pending");
                    mismatches++;
                end else begin
                    want = reply_q.pop_front();
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, o_status);
                        mismatches++;
                    end
                    if (o_pool_id !== want.pool) begin
                        $error("pool_id: expected %0d, actual %0d", want.pool, o_pool_id);
                        mismatches++;
                    end
                    if (o_block_index !== want.block) begin
                        $error("block_index: expected %0d, actual %0d", want.block,
                               o_block_index);
                        mismatches++;
                    end
                    if (o_blocks_left !== want.left) begin
                        $error("blocks_left: expected %0d, actual %0d", want.left,
                               o_blocks_left);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                in_taken++;
                rq = '0;
                rq.cmd = i_command;
                rq.size = i_request_size;
                rq.pool = i_free_pool;
                rq.block = i_free_block;
                reply_q.push_back(allocator_reply(rq));
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (psel && penable && pwrite && pready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (stall_cycles >= 1000) begin
                $display("size_class_block_allocator: mismatch");
                $finish;
            end
        end
    end

    task automatic write_size(input logic [1:0] reg_id, input logic [15:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(reg_id) << 2;
        pwdata <= 32'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        size_limit[reg_id] = value;
    endtask

    task automatic push_alloc(input logic [15:0] size);
        t_request rq;
        rq.cmd = CMD_ALLOC;
        rq.size = size;
        rq.pool = 2'($urandom_range(0, 3));
        rq.block = 5'($urandom_range(0, 31));
        rq.reuse = 1'b0;
        request_q.push_back(rq);
    endtask

    task automatic push_free(input logic [1:0] pool, input logic [4:0] block);
        t_request rq;
        rq.cmd = CMD_FREE;
        rq.size = 16'($urandom);
        rq.pool = pool;
        rq.block = block;
        rq.reuse = 1'b0;
        request_q.push_back(rq);
    endtask

    task automatic wait_drained();
        while (request_q.size() != 0 || in_sent != in_taken || reply_q.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    initial begin
        t_request rq;
        logic [15:0] lim [0:2];
        int p, b, ph, n, pct;

        pool_cap[0] = SMALL_BLOCKS;
        pool_cap[1] = MEDIUM_BLOCKS;
        pool_cap[2] = LARGE_BLOCKS;
        for (p = 0; p < 3; p++) begin
            for (b = 0; b < 32; b++) begin
                pool_next[p][b] = (b + 1 < pool_cap[p]) ? 5'(b + 1) : 5'd0;
                in_use[p][b] = 1'b0;
            end
            pool_head[p] = '0;
            pool_free[p] = pool_cap[p];
        end
        size_limit[0] = SMALL_SIZE_RST;
        size_limit[1] = MEDIUM_SIZE_RST;
        size_limit[2] = LARGE_SIZE_RST;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Class boundaries, oversize requests, bad and double frees, and an emptied pool.
        push_alloc(16'd0);
        push_alloc(16'd16);
        push_alloc(16'd17);
        push_alloc(16'd64);
        push_alloc(16'd65);
        push_alloc(16'd256);
        push_alloc(16'd257);
        push_alloc(16'hFFFF);
        push_free(POOL_SMALL, 5'd0);
        push_free(POOL_SMALL, 5'd0);
        push_free(POOL_SMALL, 5'd5);
        push_free(POOL_NONE, 5'd1);
        push_free(POOL_MEDIUM, 5'd16);
        push_free(POOL_LARGE, 5'd31);
        for (n = 0; n < 7; n++) push_alloc(16'd200);
        push_free(POOL_LARGE, 5'd7);
        push_free(POOL_LARGE, 5'd3);
        wait_drained();

        for (ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin lim[0] = 16'd16; lim[1] = 16'd64; lim[2] = 16'd256; end
                1: begin lim[0] = 16'd1; lim[1] = 16'd2; lim[2] = 16'hFFFF; end
                2: begin lim[0] = 16'hFFFF; lim[1] = 16'hFFFF; lim[2] = 16'hFFFF; end
                3: begin lim[0] = 16'd300; lim[1] = 16'd100; lim[2] = 16'd200; end
                4: begin
                    lim[0] = 16'($urandom_range(1, 1000));
                    lim[1] = lim[0] + 16'($urandom_range(1, 1000));
                    lim[2] = lim[1] + 16'($urandom_range(1, 20000));
                end
                default: begin lim[0] = 16'd1; lim[1] = 16'd1; lim[2] = 16'd1; end
            endcase
            write_size(REG_SMALL, lim[0]);
            write_size(REG_MEDIUM, lim[1]);
            write_size(REG_LARGE, lim[2]);
            settings++;

            pct = 50;
            for (n = 0; n < 272; n++) begin
                if (n % 40 == 0) begin
                    case ($urandom_range(0, 2))
                        0: pct = 15;
                        1: pct = 50;
                        default: pct = 85;
                    endcase
                end
                rq.cmd = ($urandom_range(0, 99) < pct) ? CMD_ALLOC : CMD_FREE;
                case ($urandom_range(0, 9))
                    0: rq.size = 16'd0;
                    1: rq.size = size_limit[0];
                    2: rq.size = size_limit[0] + 16'd1;
                    3: rq.size = size_limit[1];
                    4: rq.size = size_limit[1] + 16'd1;
                    5: rq.size = size_limit[2];
                    6: rq.size = size_limit[2] + 16'd1;
                    7: rq.size = 16'($urandom);
                    8: rq.size = 16'hFFFF;
                    default: rq.size = 16'($urandom_range(0, size_limit[2]));
                endcase
                rq.pool = 2'($urandom_range(0, 2));
                rq.block = 5'($urandom_range(0, pool_cap[rq.pool] - 1));
                rq.reuse = 1'b0;
                case ($urandom_range(0, 9))
                    0: begin
                        rq.pool = 2'($urandom_range(0, 3));
                        rq.block = 5'($urandom_range(0, 31));
                    end
                    1, 2: rq.reuse = 1'b0;
                    default: rq.reuse = 1'b1;
                endcase
                request_q.push_back(rq);
            end
            wait_drained();
        end

        repeat (10) @(negedge i_clk);
        $display("Ran %0d transactions over %0d size settings after the directed sequence:",
                 in_taken, settings);
        $display("%0d allocated, %0d pool empty, %0d oversize, %0d freed, %0d frees refused.",
                 n_alloc, n_empty, n_too_big, n_freed, n_refused);
        if (mismatches == 0) begin
            $display("size_class_block_allocator: match");
        end else begin
            $display("size_class_block_allocator: mismatch");
        end
        $finish;
    end

endmodule

/* size_class_block_allocator.f */
hw/rtl/scba_pkg.sv
hw/rtl/scba_ram.sv
hw/rtl/scba_cfg.sv
hw/rtl/scba_ctrl.sv
hw/rtl/scba_dp.sv
hw/rtl/size_class_block_allocator.sv
test/tb_size_class_block_allocator.sv
